>>> sv/mp2_pkg.sv
// Shared types and constants for the 2x2 stride-2 max pooling stream.
// Used by the front end, back end and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mp2_pkg;

    // Default sizes of the top level parameters
    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_HEIGHT   = 64;
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_SAMPLE_BITS  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int HEIGHT_W = 7;
    localparam int WIDTH_W  = 7;
    localparam int CHAN_W   = 5;
    localparam int BATCH_W  = 8;

    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 7'd28;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 7'd28;
    localparam logic [CHAN_W-1:0]   RST_CHAN   = 5'd1;
    localparam logic [BATCH_W-1:0]  RST_BATCH  = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT     = 2'd0,
        CFG_IN_WIDTH      = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2,
        CFG_BATCH_COUNT   = 2'd3
    } t_cfg_idx;

    // Result coordinate widths
    localparam int IMG_W  = 8;
    localparam int OROW_W = 5;
    localparam int OCOL_W = 5;
    localparam int OCH_W  = 4;

    // Queue depths
    localparam int DQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    typedef struct packed {
        logic [IMG_W-1:0]  image_index;
        logic [OROW_W-1:0] out_row;
        logic [OCOL_W-1:0] out_col;
        logic [OCH_W-1:0]  out_channel;
        logic              last_of_image;
        logic              last_of_batch;
    } t_res_tag;

    // Work descriptor handed from the front to the back
    typedef struct packed {
        t_res_tag res;
        logic     first;   // opens the window: store the sample as is
        logic     emit;    // closes the window: deliver a result
    } t_tag;

    typedef struct packed {
        logic out_push;
        logic out_full;
    } t_back_stat;

endpackage

`default_nettype wire

>>> sv/mp2_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-during-write to the same address returns the old contents.
`timescale 1ns / 1ps
`default_nettype none

module mp2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/mp2_fifo.sv
// Small register FIFO with show-ahead head and occupancy count.
// Generic; used for the work queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module mp2_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic      [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/mp2_front.sv
// Front end: configuration registers, sample position counters and window
// classification. Emits one work descriptor per in-window sample. Uses mp2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mp2_front #(
    parameter int MAX_WIDTH    = mp2_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = mp2_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = mp2_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mp2_pkg::DEF_SAMPLE_BITS,
    parameter int DEPTH        = (MAX_WIDTH / 2) * MAX_CHANNELS,
    parameter int AB           = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mp2_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [mp2_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_accept,
    input  wire logic [SAMPLE_BITS-1:0]          i_sample,
    output logic                                 o_q_push,
    output mp2_pkg::t_tag                        o_tag,
    output logic      [AB-1:0]                   o_addr,
    output logic      [SAMPLE_BITS-1:0]          o_sample
);

    import mp2_pkg::*;

    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int CB = $clog2(MAX_CHANNELS + 1);
    localparam int RB = $clog2(MAX_HEIGHT);
    localparam int XB = $clog2(MAX_WIDTH);
    localparam int KB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [HEIGHT_W-1:0] r_in_height;
    logic [WIDTH_W-1:0]  r_in_width;
    logic [CHAN_W-1:0]   r_chan_count;
    logic [BATCH_W-1:0]  r_batch_count;

    logic [RB-1:0]      r_row, n_row;
    logic [XB-1:0]      r_col, n_col;
    logic [KB-1:0]      r_ch,  n_ch;
    logic [IMG_W-1:0]   r_img, n_img;

    logic [HB-1:0]      w_h;
    logic [WB-1:0]      w_w;
    logic [CB-1:0]      w_c;
    logic [BATCH_W-1:0] w_b;
    logic               w_in_win, w_last_img;

    // Saturate the counts in use
    always_comb begin
        if (r_in_height < HEIGHT_W'(2)) begin
            w_h = HB'(2);
        end else if (32'(r_in_height) > MAX_HEIGHT) begin
            w_h = HB'(MAX_HEIGHT);
        end else begin
            w_h = HB'(r_in_height);
        end
        if (r_in_width < WIDTH_W'(2)) begin
            w_w = WB'(2);
        end else if (32'(r_in_width) > MAX_WIDTH) begin
            w_w = WB'(MAX_WIDTH);
        end else begin
            w_w = WB'(r_in_width);
        end
        if (r_chan_count == '0) begin
            w_c = CB'(1);
        end else if (32'(r_chan_count) > MAX_CHANNELS) begin
            w_c = CB'(MAX_CHANNELS);
        end else begin
            w_c = CB'(r_chan_count);
        end
        w_b = (r_batch_count == '0) ? BATCH_W'(1) : r_batch_count;
    end

    // Odd trailing row or column falls outside every window
    assign w_in_win = (HB'(r_row) < {w_h[HB-1:1], 1'b0})
                   && (WB'(r_col) < {w_w[WB-1:1], 1'b0})
                   && (CB'(r_ch) < w_c);

    assign w_last_img = ((HB'(r_row) >> 1) == (w_h >> 1) - HB'(1))
                     && ((WB'(r_col) >> 1) == (w_w >> 1) - WB'(1))
                     && (CB'(r_ch) == w_c - CB'(1));

    always_comb begin
        o_q_push                 = i_accept && w_in_win;
        o_tag.first              = !(r_row[0] | r_col[0]);
        o_tag.emit               = r_row[0] & r_col[0];
        o_tag.res.image_index    = r_img;
        o_tag.res.out_row        = OROW_W'(r_row >> 1);
        o_tag.res.out_col        = OCOL_W'(r_col >> 1);
        o_tag.res.out_channel    = OCH_W'(r_ch);
        o_tag.res.last_of_image  = w_last_img;
        o_tag.res.last_of_batch  = w_last_img && (r_img == w_b - BATCH_W'(1));
        o_addr   = AB'(32'(r_col >> 1) * MAX_CHANNELS + 32'(r_ch));
        o_sample = i_sample;
    end

    // Advance channel, column, row, image
    always_comb begin
        n_ch  = r_ch;
        n_col = r_col;
        n_row = r_row;
        n_img = r_img;
        if (CB'(r_ch) + CB'(1) >= w_c) begin
            n_ch = '0;
            if (WB'(r_col) + WB'(1) >= w_w) begin
                n_col = '0;
                if (HB'(r_row) + HB'(1) >= w_h) begin
                    n_row = '0;
                    if ({1'b0, r_img} + 9'd1 >= {1'b0, w_b}) begin
                        n_img = '0;
                    end else begin
                        n_img = r_img + IMG_W'(1);
                    end
                end else begin
                    n_row = r_row + RB'(1);
                end
            end else begin
                n_col = r_col + XB'(1);
            end
        end else begin
            n_ch = r_ch + KB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height   <= RST_HEIGHT;
            r_in_width    <= RST_WIDTH;
            r_chan_count  <= RST_CHAN;
            r_batch_count <= RST_BATCH;
            r_row         <= '0;
            r_col         <= '0;
            r_ch          <= '0;
            r_img         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_IN_HEIGHT:     r_in_height   <= i_cfg_data[HEIGHT_W-1:0];
                    CFG_IN_WIDTH:      r_in_width    <= i_cfg_data[WIDTH_W-1:0];
                    CFG_CHANNEL_COUNT: r_chan_count  <= i_cfg_data[CHAN_W-1:0];
                    CFG_BATCH_COUNT:   r_batch_count <= i_cfg_data[BATCH_W-1:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
                r_ch  <= n_ch;
                r_img <= n_img;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/mp2_back.sv
// Back end: read-modify-write of the partial maximum store and result queue.
// Depends on mp2_pkg, mp2_ram and mp2_fifo.
`timescale 1ns / 1ps
`default_nettype none

module mp2_back #(
    parameter int SAMPLE_BITS = mp2_pkg::DEF_SAMPLE_BITS,
    parameter int DEPTH       = 512,
    parameter int AB          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_empty,
    input  wire mp2_pkg::t_tag             i_q_tag,
    input  wire logic [AB-1:0]             i_q_addr,
    input  wire logic [SAMPLE_BITS-1:0]    i_q_sample,
    output logic                           o_q_pop,
    input  wire logic                      i_pop,
    output logic                           o_empty,
    output logic      [SAMPLE_BITS-1:0]    o_value,
    output mp2_pkg::t_res_tag              o_res,
    output mp2_pkg::t_back_stat            o_stat
);

    import mp2_pkg::*;

    localparam int CW = $clog2(OQ_DEPTH + 1);
    localparam int RW = $bits(t_res_tag) + SAMPLE_BITS;

    logic                   r_vld;
    t_tag                   r_tag;
    logic [AB-1:0]          r_addr;
    logic [SAMPLE_BITS-1:0] r_sample;

    logic                   r_fwd_vld;
    logic [AB-1:0]          r_fwd_addr;
    logic [SAMPLE_BITS-1:0] r_fwd_data;

    logic [SAMPLE_BITS-1:0] w_rd_data, w_old, w_new;
    logic [CW-1:0]          w_out_cnt;
    logic                   w_out_full, w_out_push;
    logic [RW-1:0]          w_out_head;

    // Admit work only when the result queue is sure to have room
    assign o_q_pop = !i_q_empty
        && (({1'b0, w_out_cnt} + (CW + 1)'(r_vld && r_tag.emit)) < (CW + 1)'(OQ_DEPTH));

    mp2_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH),
        .AW    (AB)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_vld),
        .i_wr_addr (r_addr),
        .i_wr_data (w_new),
        .i_rd_en   (o_q_pop),
        .i_rd_addr (i_q_addr),
        .o_rd_data (w_rd_data)
    );

    // The store read that coincided with the last write returned stale data
    assign w_old = (r_fwd_vld && (r_fwd_addr == r_addr)) ? r_fwd_data : w_rd_data;

    always_comb begin
        if (r_tag.first || ($signed(r_sample) > $signed(w_old))) begin
            w_new = r_sample;
        end else begin
            w_new = w_old;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag      <= i_q_tag;
        r_addr     <= i_q_addr;
        r_sample   <= i_q_sample;
        r_fwd_addr <= r_addr;
        r_fwd_data <= w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_vld     <= o_q_pop;
            r_fwd_vld <= r_vld;
        end
    end

    assign w_out_push = r_vld && r_tag.emit;

    mp2_fifo #(
        .WIDTH (RW),
        .DEPTH (OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  ({r_tag.res, w_new}),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_out_head),
        .o_empty (o_empty),
        .o_count (w_out_cnt)
    );

    assign o_value         = w_out_head[SAMPLE_BITS-1:0];
    assign o_res           = t_res_tag'(w_out_head[RW-1:SAMPLE_BITS]);
    assign o_stat.out_push = w_out_push;
    assign o_stat.out_full = w_out_full;

endmodule

`default_nettype wire

>>> sv/max_pool_2x2_stream.sv
// Top level of the streaming 2x2 stride-2 max pooling block.
// Depends on mp2_pkg, mp2_front, mp2_fifo and mp2_back.
`timescale 1ns / 1ps
`default_nettype none

// Samples enter in image, row, column, channel order, one per clock while
// full stays low, and each 2x2 window yields its maximum with coordinates
// and end of image / end of batch marks. A sample is taken on any edge with
// push high and full low; a result passes the work queue, the update register
// and the result queue to the output ports and stays until popped. The
// sustained rate is one sample per clock, set by the single read-modify-write
// port of the partial maximum store ((MAX_WIDTH/2)*MAX_CHANNELS entries);
// back-to-back updates of one entry are forwarded. Samples of an odd last
// row or column are taken and dropped. Write configuration only while idle.
module max_pool_2x2_stream #(
    parameter int MAX_WIDTH    = mp2_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = mp2_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = mp2_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mp2_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [mp2_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mp2_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [SAMPLE_BITS-1:0]           i_sample,
    input  wire logic                             pop,
    output logic                                  empty,
    output logic      [SAMPLE_BITS-1:0]           o_pooled_value,
    output logic      [mp2_pkg::IMG_W-1:0]        o_image_index,
    output logic      [mp2_pkg::OROW_W-1:0]       o_out_row,
    output logic      [mp2_pkg::OCOL_W-1:0]       o_out_col,
    output logic      [mp2_pkg::OCH_W-1:0]        o_out_channel,
    output logic                                  o_last_of_image,
    output logic                                  o_last_of_batch
);

    import mp2_pkg::*;

    localparam int DEPTH = (MAX_WIDTH / 2) * MAX_CHANNELS;
    localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $bits(t_tag);
    localparam int QW    = TW + AB + SAMPLE_BITS;
    localparam int QCW   = $clog2(DQ_DEPTH + 1);

    logic                   w_accept;
    logic                   w_q_push, w_q_full, w_q_empty, w_q_pop;
    t_tag                   w_f_tag;
    logic [AB-1:0]          w_f_addr;
    logic [SAMPLE_BITS-1:0] w_f_sample;
    logic [QW-1:0]          w_q_head;
    logic [QCW-1:0]         w_q_cnt;
    t_res_tag               w_res;
    t_back_stat             w_stat;

    assign w_accept = push && !full;
    assign full     = w_q_full;

    mp2_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .DEPTH        (DEPTH),
        .AB           (AB)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_sample   (i_sample),
        .o_q_push   (w_q_push),
        .o_tag      (w_f_tag),
        .o_addr     (w_f_addr),
        .o_sample   (w_f_sample)
    );

    mp2_fifo #(
        .WIDTH (QW),
        .DEPTH (DQ_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_f_tag, w_f_addr, w_f_sample}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_head),
        .o_empty (w_q_empty),
        .o_count (w_q_cnt)
    );

    mp2_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (DEPTH),
        .AB          (AB)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_tag    (t_tag'(w_q_head[QW-1:AB+SAMPLE_BITS])),
        .i_q_addr   (w_q_head[AB+SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_q_sample (w_q_head[SAMPLE_BITS-1:0]),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_value    (o_pooled_value),
        .o_res      (w_res),
        .o_stat     (w_stat)
    );

    assign o_image_index   = w_res.image_index;
    assign o_out_row       = w_res.out_row;
    assign o_out_col       = w_res.out_col;
    assign o_out_channel   = w_res.out_channel;
    assign o_last_of_image = w_res.last_of_image;
    assign o_last_of_batch = w_res.last_of_batch;

`ifndef SYNTHESIS
    // Result queue credit must keep every finished result
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.out_push |-> !w_stat.out_full)
        else $error("result queue overflow");

    // Back end never takes work that is not there
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("work queue popped while empty");

    // Full tracks the work queue count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (w_q_cnt == QCW'(DQ_DEPTH)))
        else $error("full without a full work queue");

    // End of batch is always also end of image
    a_last_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_of_batch) |-> o_last_of_image)
        else $error("last_of_batch without last_of_image");
`endif

endmodule

`default_nettype wire
